// File: design/nfasim_pkg.sv
// nfasim_pkg: shared types and constants of the automaton simulator
// used by nfasim_engine and nfa_epsilon_simulator, no dependencies
`default_nettype none

package nfasim_pkg;

   // automaton size and symbol alphabet
   localparam int N_STATES    = 16;
   localparam int SYMBOL_BITS = 8;
   localparam int STATE_BITS  = $clog2(N_STATES);
   localparam int ADDR_BITS   = STATE_BITS + SYMBOL_BITS;
   localparam int TABLE_DEPTH = N_STATES << SYMBOL_BITS;

   // field widths of the request and result items
   localparam int FUNC_W   = 2;
   localparam int SYM_W    = 8;
   localparam int SIDX_W   = 4;
   localparam int MASK_W   = 16;
   localparam int ACTIVE_W = 16;

   // function codes
   localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FEED  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_START_STATE = 2'd0;
   localparam logic [1:0] CSR_ACCEPT_MASK = 2'd1;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [SYM_W-1:0]  symbol;
      logic [SIDX_W-1:0] state_index;
      logic [MASK_W-1:0] next_mask;
   } nfasim_req_type;

   typedef struct packed {
      logic                valid;
      logic [N_STATES-1:0] active;
   } nfasim_res_type;

endpackage

`default_nettype wire

// File: design/nfasim_engine.sv
// nfasim_engine: transition table memory and the scan sequencer that
// builds symbol moves and epsilon closures; depends on nfasim_pkg
`default_nettype none

module nfasim_engine
   import nfasim_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire nfasim_req_type        req,
   input  wire logic [SIDX_W-1:0]     start_state,
   input  wire logic                  out_free,
   output nfasim_res_type             res
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   localparam logic [STATE_BITS:0]  SCAN_END = (STATE_BITS+1)'(N_STATES);
   localparam logic [ADDR_BITS-1:0] CLR_LAST = {ADDR_BITS{1'b1}};

   logic [1:0]             state_ff, state_in;
   logic [ADDR_BITS-1:0]   clr_ff, clr_in;
   logic [STATE_BITS:0]    cnt_ff, cnt_in;
   logic                   eps_ff, eps_in;
   logic                   chg_ff, chg_in;
   logic [SYMBOL_BITS-1:0] sym_ff, sym_in;
   logic [N_STATES-1:0]    acc_ff, acc_in;
   logic [N_STATES-1:0]    active_ff, active_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [STATE_BITS-1:0]  rd_st_ff;
   logic [N_STATES-1:0]    rd_data_ff;

   logic [N_STATES-1:0]    table_mem [TABLE_DEPTH];

   logic                   req_fire;
   logic                   issue;
   logic [ADDR_BITS-1:0]   rd_addr;
   logic                   mem_we;
   logic [ADDR_BITS-1:0]   wr_addr;
   logic [N_STATES-1:0]    wr_data;
   logic                   src_bit;
   logic [N_STATES-1:0]    merged;
   logic                   upd;
   logic [N_STATES-1:0]    acc_scan;
   logic                   grew;
   logic [SYMBOL_BITS-1:0] req_sym;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign req_sym   = req.symbol[SYMBOL_BITS-1:0];

   assign issue   = (state_ff == ST_SCAN) && (cnt_ff != SCAN_END);
   assign rd_addr = {cnt_ff[STATE_BITS-1:0], eps_ff ? {SYMBOL_BITS{1'b0}} : sym_ff};

   // the move phase tests the old set, the closure phase works in place
   assign src_bit  = eps_ff ? acc_ff[rd_st_ff] : active_ff[rd_st_ff];
   assign merged   = acc_ff | rd_data_ff;
   assign upd      = rd_vld_ff && src_bit;
   assign acc_scan = upd ? merged : acc_ff;
   assign grew     = upd && (merged != acc_ff);

   always_comb begin
      mem_we  = 1'b0;
      wr_addr = clr_ff;
      wr_data = '0;
      if (state_ff == ST_CLEAR) begin
         mem_we = 1'b1;
      end else if (req_fire && (req.func == FUNC_WRITE)) begin
         mem_we  = 1'b1;
         wr_addr = {req.state_index[STATE_BITS-1:0], req_sym};
         wr_data = req.next_mask[N_STATES-1:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      cnt_in    = cnt_ff;
      eps_in    = eps_ff;
      chg_in    = chg_ff;
      sym_in    = sym_ff;
      acc_in    = acc_ff;
      active_in = active_ff;
      rd_vld_in = issue;
      res.valid  = 1'b0;
      res.active = acc_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               cnt_in = '0;
               chg_in = 1'b0;
               sym_in = req_sym;
               priority if (req.func == FUNC_START) begin
                  acc_in   = N_STATES'(1) << start_state[STATE_BITS-1:0];
                  eps_in   = 1'b1;
                  state_in = ST_SCAN;
               end else if ((req.func == FUNC_FEED) && (req_sym != '0)) begin
                  acc_in   = '0;
                  eps_in   = 1'b0;
                  state_in = ST_SCAN;
               end else begin
                  acc_in   = active_ff;
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            acc_in = acc_scan;
            if (eps_ff && grew) begin
               chg_in = 1'b1;
            end
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end else begin
               cnt_in = '0;
               chg_in = 1'b0;
               if (!eps_ff) begin
                  eps_in = 1'b1;
               end else if (!(chg_ff || grew)) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               res.valid = 1'b1;
               active_in = acc_ff;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         cnt_ff    <= '0;
         eps_ff    <= 1'b0;
         chg_ff    <= 1'b0;
         active_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         cnt_ff    <= cnt_in;
         eps_ff    <= eps_in;
         chg_ff    <= chg_in;
         active_ff <= active_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff   <= sym_in;
      acc_ff   <= acc_in;
      rd_st_ff <= cnt_ff[STATE_BITS-1:0];
   end

   // transition table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   // a symbol scan starts from an empty set
   a_feed_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req.func == FUNC_FEED) && (req_sym != '0))
      |=> (acc_ff == '0) && (state_ff == ST_SCAN) && !eps_ff)
      else $error("feed did not start an empty move scan");

   // closure only ever adds states
   a_closure_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && eps_ff
      |=> ((acc_ff & $past(acc_ff)) == $past(acc_ff)))
      else $error("closure dropped an active state");

   // read data only returns for reads issued by a scan
   a_read_source: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(state_ff == ST_SCAN))
      else $error("table read data without a scan");

   // a result leaves only when the output stage can take it
   a_result_slot: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> out_free && (state_ff == ST_DONE) && $past(state_ff != ST_CLEAR))
      else $error("result produced with output stage busy");

endmodule

`default_nettype wire

// File: design/nfa_epsilon_simulator.sv
// result: rsp_tvalid rises once the output register takes the result; a table write,
// unused code or epsilon feed skips the scan; a start first runs (k+1) closure passes,
// a feed one move pass plus those, k the passes that add states (<= 15)
// throughput: one request at a time, the next is taken once the result has
// entered the output register; a pass reads one table entry per state per cycle
// reset: a sweep clears all 4096 table entries with req_tready low, csr writes taken
`default_nettype none

module nfa_epsilon_simulator
   import nfasim_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // symbol, state_index, next_mask, zero fill
   input  wire logic [1:0]  req_tuser,  // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // active_states, accepted, zero fill
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   logic [SIDX_W-1:0]   start_ff;
   logic [MASK_W-1:0]   accept_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [23:0]         rsp_data_ff;
   logic                out_free;
   nfasim_req_type      req;
   nfasim_res_type      res;
   logic [ACTIVE_W-1:0] res_active;

   assign req.func        = req_tuser;
   assign req.symbol      = req_tdata[7:0];
   assign req.state_index = req_tdata[11:8];
   assign req.next_mask   = req_tdata[27:12];

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   nfasim_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req         (req),
      .start_state (start_ff),
      .out_free    (out_free),
      .res         (res)
   );

   assign res_active = ACTIVE_W'(res.active);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         accept_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_START_STATE: start_ff  <= csr_data[SIDX_W-1:0];
            CSR_ACCEPT_MASK: accept_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // output register parts the engine from the result channel
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid) begin
         rsp_data_ff <= {7'd0, |(res_active & accept_ff), res_active};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
